// ===== src/chained_hash_key_table_unit_macros.svh =====
// Assertion macros for the chained hash key table unit.
// No dependencies; included by the top level.
`ifndef CHAINED_HASH_KEY_TABLE_UNIT_MACROS_SVH
`define CHAINED_HASH_KEY_TABLE_UNIT_MACROS_SVH
// Implication that holds outside reset.
`define CHKT_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication that holds outside reset.
`define CHKT_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/chkt_pkg.sv =====
// Package for the chained hash key table unit: payload structs, sizes and codes.
// No dependencies.
`timescale 1ns / 1ps
package chkt_pkg;
  localparam int MAX_BUCKETS = 1024;
  localparam int POOL_NODES  = 1024;
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_EXISTS = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [10:0] TOTAL_MAX = 11'd2047;
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [9:0]  node_handle;
  } in_item_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  found_handle;
    logic [10:0] stored_keys;
  } out_item_t;
endpackage

// ===== src/chkt_mod_unit.sv =====
// Serial restoring remainder unit: key modulo bucket count, one bit a cycle.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module chkt_mod_unit #(
  parameter int BW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [BW-1:0] divisor,
  output logic          done,
  output logic [BW-1:0] remainder
);
  logic [31:0] quo_r, quo_nxt;
  logic [BW:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [BW+1:0] trial;

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, quo_r[31]} - {2'b00, divisor};
    if (start) begin
      quo_nxt = dividend; rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (!trial[BW+1]) rem_nxt = trial[BW:0];
      else rem_nxt = {rem_r[BW-1:0], quo_r[31]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign remainder = rem_r[BW-1:0];
endmodule

// ===== src/chained_hash_key_table_unit.sv =====
// Top level of the chained hash key table unit: sequencer and table memories.
// Depends on chkt_pkg, chkt_mod_unit and the assertion macro header.
`timescale 1ns / 1ps
// One transaction at a time. An operation first works out the bucket
// remainder (one bit a cycle in the serial remainder unit) and takes its
// result, then reads the head (S_HEAD, S_HEADW), then visits each chain
// node with an end check, a registered read of the key and link memory and
// a compare, then, if no key matched, a final end-of-chain check, then a
// write-back state and an output state. After reset a clearing pass writes
// every bucket head empty, one entry a cycle, during which no input is
// taken; configuration writes are taken throughout. The result sits in an
// output register; the next transaction is taken once the previous result
// has left.
module chained_hash_key_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chkt_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chkt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data
);
  import chkt_pkg::*;
  `include "chained_hash_key_table_unit_macros.svh"

  localparam int BA = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NA = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LW = NA + 1;           // link width, top bit set = none
  localparam int BW = $clog2(MAX_BUCKETS + 1);
  localparam int SW = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0] LINK_NONE = LW'(POOL_NODES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_HEADW, S_NODE, S_NODEW, S_CMP, S_WB, S_OUT
  } state_t;

  // Memories
  logic [LW-1:0] head_mem [MAX_BUCKETS];
  logic [LW-1:0] link_mem [POOL_NODES];
  logic [31:0]   key_mem  [POOL_NODES];

  state_t state_r;
  logic [10:0]   bcount_r;
  logic [10:0]   total_r;
  logic [BA-1:0] clr_r;
  in_item_t      item_r;
  logic [BA-1:0] bucket_r;
  logic [LW-1:0] head_q, link_q, node_r, prev_r;
  logic [31:0]   key_q;
  logic [SW-1:0] steps_r;
  logic          hit_r;
  out_item_t     res_r;
  logic          outv_r;
  out_item_t     res_nxt;
  logic [10:0]   total_nxt;

  // Effective bucket count: zero as 1, clipped to MAX_BUCKETS
  logic [BW-1:0] eff_cnt;
  always_comb begin
    if (bcount_r == 11'd0) eff_cnt = BW'(1);
    else if (32'(bcount_r) > 32'(MAX_BUCKETS)) eff_cnt = BW'(MAX_BUCKETS);
    else eff_cnt = BW'(bcount_r);
  end

  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;
  chkt_mod_unit #(.BW(BW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(in_data.key),
    .divisor(eff_cnt), .done(mod_done), .remainder(mod_rem)
  );

  logic in_acc;
  assign in_stall = (state_r != S_IDLE) || outv_r;
  assign in_acc = in_valid && !in_stall;
  assign mod_start = in_acc;
  assign cfg_ready = 1'b1;

  // Head memory port: one write, one registered read
  logic          hw_en;
  logic [BA-1:0] hw_addr;
  logic [LW-1:0] hw_data;
  // Node memories: one write, one registered read
  logic          lw_en, kw_en;
  logic [NA-1:0] nw_addr;
  logic [LW-1:0] lw_data;
  logic [NA-1:0] handle;
  assign handle = NA'(item_r.node_handle % POOL_NODES);

  always_comb begin
    hw_en = 1'b0; hw_addr = bucket_r; hw_data = LINK_NONE;
    lw_en = 1'b0; kw_en = 1'b0; nw_addr = handle; lw_data = head_q;
    if (state_r == S_CLEAR) begin
      hw_en = 1'b1; hw_addr = clr_r;
    end else if (state_r == S_WB) begin
      if (item_r.func == FUNC_INSERT && !hit_r) begin
        hw_en = 1'b1; hw_data = LW'(handle);
        lw_en = 1'b1; kw_en = 1'b1;
      end else if (item_r.func == FUNC_REMOVE && hit_r) begin
        // Unlink: link_q still holds the hit node's next link
        if (prev_r == LINK_NONE) begin
          hw_en = 1'b1; hw_data = link_q;
        end else begin
          lw_en = 1'b1; nw_addr = prev_r[NA-1:0]; lw_data = link_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) head_mem[hw_addr] <= hw_data;
    head_q <= head_mem[bucket_r];
    if (lw_en) link_mem[nw_addr] <= lw_data;
    if (kw_en) key_mem[nw_addr] <= item_r.key;
    link_q <= link_mem[node_r[NA-1:0]];
    key_q  <= key_mem[node_r[NA-1:0]];
  end

  // Result and key count for the write-back cycle
  always_comb begin
    res_nxt.status = ST_MISS;
    res_nxt.found_handle = '0;
    total_nxt = total_r;
    case (item_r.func)
      FUNC_INSERT: begin
        if (hit_r) res_nxt.status = ST_DUP;
        else begin
          res_nxt.status = ST_DONE;
          if (total_r != TOTAL_MAX) total_nxt = total_r + 11'd1;
        end
      end
      FUNC_REMOVE, FUNC_EXISTS: begin
        if (hit_r) begin
          res_nxt.status = ST_DONE;
          res_nxt.found_handle = 10'(node_r[NA-1:0]);
          if (item_r.func == FUNC_REMOVE && total_r != 11'd0)
            total_nxt = total_r - 11'd1;
        end
      end
      default: ;
    endcase
    res_nxt.stored_keys = total_nxt;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; bcount_r <= 11'd1021;
      total_r <= '0; outv_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bcount_r <= cfg_data;
      if (outv_r && !out_stall) outv_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + BA'(1);
          if (32'(clr_r) == MAX_BUCKETS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            item_r <= in_data; state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bucket_r <= BA'(mod_rem); state_r <= S_HEAD;
          end
        end
        S_HEAD: state_r <= S_HEADW;         // head read in flight
        S_HEADW: begin
          node_r <= head_q; prev_r <= LINK_NONE; steps_r <= '0; hit_r <= 1'b0;
          state_r <= S_NODE;
        end
        S_NODE: begin
          // Drop out when the walk ends or the step budget is spent
          if (node_r[LW-1] || 32'(steps_r) >= POOL_NODES) state_r <= S_WB;
          else state_r <= S_NODEW;
        end
        S_NODEW: state_r <= S_CMP;          // node read in flight
        S_CMP: begin
          if (key_q == item_r.key) begin
            hit_r <= 1'b1; state_r <= S_WB;
          end else begin
            prev_r <= node_r; node_r <= link_q;
            steps_r <= steps_r + SW'(1); state_r <= S_NODE;
          end
        end
        S_WB: begin
          res_r <= res_nxt;
          total_r <= total_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          outv_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = outv_r;
  assign out_data = res_r;

  `CHKT_ASSERT_IMP(a_no_take_busy, clk, rst_n, in_acc, state_r == S_IDLE && !outv_r, "busy take")
  `CHKT_ASSERT_NXT(a_out_follows, clk, rst_n, state_r == S_OUT, outv_r, "result not presented")
  `CHKT_ASSERT_IMP(a_clear_no_out, clk, rst_n, state_r == S_CLEAR, !outv_r, "output during clear")
endmodule
